[rtl/mrfr_pkg.sv]
// Shared types and constants for the Modbus RTU frame receiver.
package mrfr_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_MASTER_MODE      = 2'd0;
  localparam logic [1:0] CFG_OWN_ADDRESS      = 2'd1;
  localparam logic [1:0] CFG_LISTEN_BROADCAST = 2'd2;
  localparam logic [1:0] CFG_MAX_DATA_BYTES   = 2'd3;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_IDLE      = 3'd0,
    EV_BYTE      = 3'd1,
    EV_FRAME_OK  = 3'd2,
    EV_CRC_ERR   = 3'd3,
    EV_ADDR_MISS = 3'd4,
    EV_UNK_FUNC  = 3'd5,
    EV_SIZE_ERR  = 3'd6
  } event_t;

  // Input command codes.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_IDLE = 1'b1;

  typedef struct packed {
    logic       master_mode;
    logic [7:0] own_address;
    logic       listen_broadcast;
    logic [7:0] max_data_bytes;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    logic [7:0] unit_id;
    logic [7:0] function_code;
    logic [7:0] payload_length;
  } out_item_t;

endpackage

[rtl/mrfr_stream_if.sv]
// Valid/ready stream channel carrying one payload item per transaction.
interface mrfr_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/mrfr_cfg_regs.sv]
// Configuration register file of the frame receiver.
module mrfr_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output mrfr_pkg::cfg_t      cfg
);

  mrfr_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.master_mode      <= 1'b0;
      regs.own_address      <= 8'd1;
      regs.listen_broadcast <= 1'b0;
      regs.max_data_bytes   <= 8'd242;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mrfr_pkg::CFG_MASTER_MODE:      regs.master_mode      <= cfg_data[0];
        mrfr_pkg::CFG_OWN_ADDRESS:      regs.own_address      <= cfg_data;
        mrfr_pkg::CFG_LISTEN_BROADCAST: regs.listen_broadcast <= cfg_data[0];
        mrfr_pkg::CFG_MAX_DATA_BYTES:   regs.max_data_bytes   <= cfg_data;
      endcase
    end
  end

  assign cfg = regs;

endmodule

[rtl/mrfr_frame_engine.sv]
// Frame tracking state, function decoding and CRC-16 check for one item per cycle while step is high.
module mrfr_frame_engine #(
  parameter int FRAME_BYTES = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  mrfr_pkg::in_item_t  item,
  input  mrfr_pkg::cfg_t      cfg,
  output mrfr_pkg::out_item_t result
);

  typedef enum logic [2:0] {
    KIND_NONE = 3'b001,
    KIND_VAR  = 3'b010,
    KIND_FIX  = 3'b100
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] pos;
    logic [3:0] len;
  } decode_t;

  localparam logic [8:0] FrameLimit = 9'(FRAME_BYTES);

  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  frame_end, frame_end_next;
  logic [7:0]  func_seen, func_seen_next;
  logic [7:0]  unit_seen, unit_seen_next;
  kind_t       frame_kind, frame_kind_next;
  logic [3:0]  length_position, length_position_next;
  logic [15:0] running_crc, running_crc_next;

  // Modbus CRC-16, reflected polynomial 0xA001, one byte per call.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ 16'hA001;
      else      c = c >> 1;
    end
    return c;
  endfunction

  function automatic decode_t decode_func(input logic master, input logic [7:0] f);
    decode_t d;
    d.kind = KIND_NONE;
    d.pos  = 4'd0;
    d.len  = 4'd0;
    if (master) begin
      if (f >= 8'd1 && f <= 8'd4) begin
        d.kind = KIND_VAR;
        d.pos  = 4'd2;
      end else if (f == 8'd5 || f == 8'd6 || f == 8'd15 || f == 8'd16) begin
        d.kind = KIND_FIX;
        d.len  = 4'd8;
      end
      // Exception responses are always five bytes long.
      if (f[7]) begin
        d.kind = KIND_FIX;
        d.len  = 4'd5;
        d.pos  = 4'd0;
      end
    end else begin
      if (f == 8'd15 || f == 8'd16) begin
        d.kind = KIND_VAR;
        d.pos  = 4'd6;
      end else if (f == 8'd23) begin
        d.kind = KIND_VAR;
        d.pos  = 4'd10;
      end else if (f >= 8'd1 && f <= 8'd6) begin
        d.kind = KIND_FIX;
        d.len  = 4'd8;
      end else if (f == 8'd43) begin
        d.kind = KIND_FIX;
        d.len  = 4'd7;
      end else if (f == 8'd22) begin
        d.kind = KIND_FIX;
        d.len  = 4'd10;
      end else if (f == 8'd7 || f == 8'd17) begin
        d.kind = KIND_FIX;
        d.len  = 4'd4;
      end
    end
    return d;
  endfunction

  logic [7:0]  b;
  logic [15:0] crc_upd;
  logic [8:0]  end_sum;
  logic [7:0]  count_inc;
  decode_t     dec;
  logic        take;
  logic        finish;
  logic        clr;

  assign b         = item.rx_byte;
  assign crc_upd   = crc_byte(running_crc, b);
  assign end_sum   = {1'b0, b} + {1'b0, byte_count} + 9'd3;
  assign count_inc = byte_count + 8'd1;
  assign dec       = decode_func(cfg.master_mode, b);

  always_comb begin
    result               = '0;
    take                 = 1'b0;
    finish               = 1'b0;
    clr                  = 1'b0;
    byte_count_next      = byte_count;
    frame_end_next       = frame_end;
    func_seen_next       = func_seen;
    unit_seen_next       = unit_seen;
    frame_kind_next      = frame_kind;
    length_position_next = length_position;
    running_crc_next     = running_crc;

    if (item.cmd == mrfr_pkg::CMD_IDLE) begin
      clr = 1'b1;
    end else if (byte_count == 8'd0) begin
      if (cfg.master_mode || b == cfg.own_address || (cfg.listen_broadcast && b == 8'd0)) begin
        unit_seen_next = b;
        take           = 1'b1;
      end else begin
        result.event_res = mrfr_pkg::EV_ADDR_MISS;
      end
    end else if (byte_count == 8'd1) begin
      func_seen_next       = b;
      frame_kind_next      = dec.kind;
      length_position_next = dec.pos;
      frame_end_next       = {4'd0, dec.len};
      take                 = 1'b1;
    end else begin
      unique case (frame_kind)
        KIND_VAR: begin
          if (byte_count < {4'd0, length_position}) begin
            take = 1'b1;
          end else if (byte_count == {4'd0, length_position}) begin
            if (b > cfg.max_data_bytes || end_sum > 9'd255 || end_sum > FrameLimit) begin
              result.event_res     = mrfr_pkg::EV_SIZE_ERR;
              result.unit_id       = unit_seen;
              result.function_code = func_seen;
              clr                  = 1'b1;
            end else begin
              take           = 1'b1;
              frame_end_next = end_sum[7:0];
            end
          end else if (frame_end > byte_count) begin
            take   = 1'b1;
            finish = (count_inc == frame_end);
          end
        end
        KIND_FIX: begin
          take   = 1'b1;
          finish = (count_inc >= frame_end);
        end
        KIND_NONE: begin
          result.event_res     = mrfr_pkg::EV_UNK_FUNC;
          result.unit_id       = unit_seen;
          result.function_code = func_seen;
          clr                  = 1'b1;
        end
        default: begin
          clr = 1'b1;
        end
      endcase
    end

    if (take) begin
      result.event_res     = mrfr_pkg::EV_BYTE;
      result.byte_value    = b;
      result.byte_index    = byte_count;
      result.unit_id       = unit_seen_next;
      result.function_code = func_seen_next;
      running_crc_next     = crc_upd;
      byte_count_next      = count_inc;
    end

    // A good frame leaves a zero CRC residue after its two CRC bytes.
    if (finish) begin
      clr = 1'b1;
      if (crc_upd == 16'h0000) begin
        result.event_res      = mrfr_pkg::EV_FRAME_OK;
        result.payload_length = byte_count - 8'd3;
      end else begin
        result.event_res = mrfr_pkg::EV_CRC_ERR;
      end
    end

    if (clr) begin
      byte_count_next      = 8'd0;
      frame_end_next       = 8'd0;
      func_seen_next       = 8'd0;
      unit_seen_next       = 8'd0;
      frame_kind_next      = KIND_NONE;
      length_position_next = 4'd0;
      running_crc_next     = 16'hFFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= 8'd0;
      frame_end       <= 8'd0;
      func_seen       <= 8'd0;
      unit_seen       <= 8'd0;
      frame_kind      <= KIND_NONE;
      length_position <= 4'd0;
      running_crc     <= 16'hFFFF;
    end else if (step) begin
      byte_count      <= byte_count_next;
      frame_end       <= frame_end_next;
      func_seen       <= func_seen_next;
      unit_seen       <= unit_seen_next;
      frame_kind      <= frame_kind_next;
      length_position <= length_position_next;
      running_crc     <= running_crc_next;
    end
  end

endmodule

[rtl/modbus_rtu_frame_receiver.sv]
// Modbus RTU frame receiver: receive-side framing, address filter and CRC-16 check.
//
// Input channel in_ch carries one transaction per received character (cmd = 0,
// rx_byte) or per line-idle gap (cmd = 1), which clears the frame in progress.
// Output channel out_ch returns exactly one result per input transaction: the
// event code, the accepted byte with its index, the frame's unit and function
// bytes, and on a good frame the payload length.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user must
// write it only while the block is idle, which the block itself does not enforce;
// index 0 master_mode, 1 own_address, 2 listen_broadcast, 3 max_data_bytes.
// An input transaction passes through one input register, then the frame engine
// (CRC byte update, decode and compares) writes the result register.
// Throughput is one item per cycle while out_ch does not stall.
// A synchronous reset empties both registers, clears the frame state and
// restores the register defaults. When out_ch stalls, the result register
// holds; the input register takes one more item only if it is empty, and
// in_ch.ready drops once it holds an item.
module modbus_rtu_frame_receiver #(
  parameter int FRAME_BYTES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  mrfr_stream_if.sink          in_ch,
  mrfr_stream_if.source        out_ch,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data
);

  mrfr_pkg::cfg_t      cfg;
  mrfr_pkg::in_item_t  in_q;
  logic                in_v;
  mrfr_pkg::out_item_t out_q;
  logic                out_v;
  mrfr_pkg::out_item_t result;
  logic                step;

  assign step        = in_v && (!out_v || out_ch.ready);
  assign in_ch.ready = !in_v || step;

  mrfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mrfr_frame_engine #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_q),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_ch.ready) begin
      in_v <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_q <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (step) begin
      out_v <= 1'b1;
    end else if (out_ch.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_ch.valid = out_v;
  assign out_ch.data  = out_q;

endmodule
